[src/sps_pkg.sv]
// Shared types and constants for the stepper pulse sequencer.
// No dependencies; every other file imports this package.
package sps_pkg;

  localparam int unsigned CountW  = 16;
  localparam int unsigned SensorW = 16;
  localparam int unsigned SelW    = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CountW-1:0] TimerMax      = '1;
  localparam logic [CountW-1:0] StepDelayRst  = 16'd1000;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } sps_cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STEP_COUNT    = 3'd0,
    REG_EXTRA_STEPS   = 3'd1,
    REG_SENSOR_MODE   = 3'd2,
    REG_SENSOR_BIT    = 3'd3,
    REG_BRAKE_PRESENT = 3'd4,
    REG_STEP_DELAY    = 3'd5
  } sps_reg_e;

  typedef struct packed {
    logic [CountW-1:0] step_count;
    logic [CountW-1:0] extra_steps;
    logic              sensor_mode;
    logic [SelW-1:0]   sensor_bit;
    logic              brake_present;
    logic [CountW-1:0] step_delay;
  } sps_cfg_t;

  typedef struct packed {
    logic              running;
    logic [CountW-1:0] step_counter;
    logic [CountW-1:0] delay_timer;
    logic              limit_hit;
    logic [CountW-1:0] extra_left;
    logic              relay_state;
  } sps_state_t;

  typedef struct packed {
    logic              step_pulse;
    logic              brake_relay_on;
    logic              done_res;
    logic              busy_res;
    logic [CountW-1:0] steps_taken;
    logic              sensor_seen;
  } sps_result_t;

endpackage

[src/sps_intf.sv]
// Handshake channel interfaces: command input, result output, register write.
// Depends on sps_pkg for field widths.
interface sps_in_if import sps_pkg::*; ;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [SensorW-1:0] sensor_word;

  modport source (output valid, cmd, sensor_word, input ready);
  modport sink   (input valid, cmd, sensor_word, output ready);
endinterface

interface sps_out_if import sps_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              step_pulse;
  logic              brake_relay_on;
  logic              done_res;
  logic              busy_res;
  logic [CountW-1:0] steps_taken;
  logic              sensor_seen;

  modport source (output valid, step_pulse, brake_relay_on, done_res, busy_res,
                  steps_taken, sensor_seen, input ready);
  modport sink   (input valid, step_pulse, brake_relay_on, done_res, busy_res,
                  steps_taken, sensor_seen, output ready);
endinterface

interface sps_cfg_if import sps_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/sps_step.sv]
// Next-state and result logic for one command beat.
// Depends on sps_pkg.
module sps_step import sps_pkg::*; (
  input  sps_cfg_t           cfg_i,
  input  sps_state_t         state_i,
  input  logic               cmd_i,
  input  logic [SensorW-1:0] sensor_word_i,
  output sps_state_t         state_o,
  output sps_result_t        result_o
);

  logic [CountW-1:0] timer_inc;
  logic              pulse;
  logic              done;
  logic              finish;

  always_comb begin
    state_o   = state_i;
    pulse     = 1'b0;
    done      = 1'b0;
    finish    = 1'b0;
    timer_inc = (state_i.delay_timer != TimerMax) ? state_i.delay_timer + 1'b1
                                                  : state_i.delay_timer;
    if (cmd_i == CMD_START) begin
      state_o.running = 1'b1;
      if (cfg_i.brake_present) begin
        state_o.relay_state = 1'b1;
      end
      state_o.limit_hit    = 1'b0;
      state_o.extra_left   = cfg_i.extra_steps;
      state_o.step_counter = CountW'(1);
      state_o.delay_timer  = '0;
      pulse                = 1'b1;
    end else if (state_i.running) begin
      state_o.delay_timer = timer_inc;
      if (timer_inc >= cfg_i.step_delay) begin
        if (cfg_i.sensor_mode && !state_i.limit_hit) begin
          if (sensor_word_i[cfg_i.sensor_bit]) begin
            state_o.limit_hit = 1'b1;
          end
        end else if (cfg_i.sensor_mode) begin
          if (state_i.extra_left == '0) begin
            finish = 1'b1;
          end else begin
            state_o.extra_left = state_i.extra_left - 1'b1;
          end
        end else begin
          finish = (state_i.step_counter == cfg_i.step_count);
        end
        if (finish) begin
          state_o.running     = 1'b0;
          state_o.relay_state = 1'b0;
          done                = 1'b1;
        end else begin
          state_o.step_counter = state_i.step_counter + 1'b1;
          state_o.delay_timer  = '0;
          pulse                = 1'b1;
        end
      end
    end

    result_o.step_pulse     = pulse;
    result_o.brake_relay_on = state_o.relay_state;
    result_o.done_res       = done;
    result_o.busy_res       = state_o.running;
    result_o.steps_taken    = state_o.step_counter;
    result_o.sensor_seen    = state_o.limit_hit;
  end

endmodule

[src/stepper_pulse_sequencer.sv]
// Stepper pulse sequencer: top level with registers, state and result stage.
// Depends on sps_pkg, sps_intf (channel interfaces) and sps_step.
//
// Usage: in_i carries command beats (cmd = start or one-microsecond tick, plus
// the sensor word); each accepted beat yields exactly one result beat on out_o.
// cfg_i writes register <index> with <data>; it is always ready and should be
// used only while no command beat is outstanding.
// Latency: a result is valid the cycle after its command beat is accepted.
// Throughput: one beat per cycle while out_o.ready is high; the state update
// and the result are formed in one pass of the step logic between the state
// registers and the result register.
// Stall: the result register holds while out_o.ready is low; in_i.ready is
// high when the result register is empty or being drained this cycle, so a
// stalled receiver stalls the sender after one beat.
// Reset (rst_ni low, asynchronous): run state cleared, registers at defaults
// (step_delay 1000, others 0), no result pending.
module stepper_pulse_sequencer import sps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sps_in_if.sink    in_i,
  sps_out_if.source out_o,
  sps_cfg_if.sink   cfg_i
);

  sps_cfg_t    cfg_q;
  sps_state_t  state_q, state_d;
  sps_result_t result_q, result_d;
  logic        out_valid_q;
  logic        in_acc;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_acc      = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{step_delay: StepDelayRst, default: '0};
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_STEP_COUNT:    cfg_q.step_count    <= cfg_i.data;
        REG_EXTRA_STEPS:   cfg_q.extra_steps   <= cfg_i.data;
        REG_SENSOR_MODE:   cfg_q.sensor_mode   <= cfg_i.data[0];
        REG_SENSOR_BIT:    cfg_q.sensor_bit    <= cfg_i.data[SelW-1:0];
        REG_BRAKE_PRESENT: cfg_q.brake_present <= cfg_i.data[0];
        REG_STEP_DELAY:    cfg_q.step_delay    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  sps_step u_step (
    .cfg_i         (cfg_q),
    .state_i       (state_q),
    .cmd_i         (in_i.cmd),
    .sensor_word_i (in_i.sensor_word),
    .state_o       (state_d),
    .result_o      (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      state_q     <= state_d;
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.step_pulse     = result_q.step_pulse;
  assign out_o.brake_relay_on = result_q.brake_relay_on;
  assign out_o.done_res       = result_q.done_res;
  assign out_o.busy_res       = result_q.busy_res;
  assign out_o.steps_taken    = result_q.steps_taken;
  assign out_o.sensor_seen    = result_q.sensor_seen;

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.done_res |-> !out_o.busy_res && !out_o.step_pulse)
    else $error("done beat reports busy or pulse");

  a_start_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_i.cmd == CMD_START) |=>
      out_o.valid && out_o.step_pulse && out_o.busy_res &&
      (out_o.steps_taken == CountW'(1)) && !out_o.sensor_seen)
    else $error("start beat did not produce first pulse");

  a_relay_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.busy_res |-> !out_o.brake_relay_on)
    else $error("relay driven while idle");

  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_i.cmd == CMD_TICK) && !state_q.running |=>
      out_o.valid && !out_o.step_pulse && !out_o.done_res && !out_o.busy_res)
    else $error("tick while idle changed run state");

endmodule
